// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of the record parser.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/tfrp_pkg.sv =====
// Shared types, character codes and helpers for the text frame record parser.
// No dependencies; used by the channel interfaces and the parser itself.
package tfrp_pkg;

  // Field widths of the request and result
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned TEXT_W      = 64;
  localparam int unsigned LABEL_LEN_W = 4;
  localparam int unsigned VALUE_LEN_W = 6;

  // Label buffer holds up to eight characters, value buffer up to 32
  localparam int unsigned LABEL_BYTES     = 9;
  localparam int unsigned LABEL_MAX       = LABEL_BYTES - 1;
  localparam int unsigned VALUE_WORDS     = 4;
  localparam int unsigned VALUE_SLOTS     = VALUE_WORDS * (TEXT_W / BYTE_W);
  localparam int unsigned VALUE_BYTES_DEF = 33;

  // Characters of interest
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LOW_A = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LOW_Z = 8'h7A;
  localparam logic [BYTE_W-1:0] CASE_GAP = 8'h20;

  // "CHECKSUM", first character in bits 7:0
  localparam logic [TEXT_W-1:0] CSUM_LABEL = 64'h4D55_534B_4345_4843;

  // Result kinds
  localparam logic EV_RECORD    = 1'b0;
  localparam logic EV_FRAME_END = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_BEGIN = 3'd1,
    PH_LABEL = 3'd2,
    PH_VALUE = 3'd3,
    PH_CSUM  = 3'd4
  } parse_phase_t;

  // Upper-case a..z, everything else passes
  function automatic logic [BYTE_W-1:0] upcase(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
      r = c - CASE_GAP;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/tfrp_ifs.sv =====
// Valid/ready channel interfaces for the byte request and the parsed result.
// Depends on tfrp_pkg for field widths.
interface tfrp_in_if;
  import tfrp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tfrp_out_if;
  import tfrp_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   event_kind;
  logic [TEXT_W-1:0]      label_text;
  logic [LABEL_LEN_W-1:0] label_length;
  logic [TEXT_W-1:0]      value_word0;
  logic [TEXT_W-1:0]      value_word1;
  logic [TEXT_W-1:0]      value_word2;
  logic [TEXT_W-1:0]      value_word3;
  logic [VALUE_LEN_W-1:0] value_length;
  logic                   frame_valid;

  modport source (output valid, output event_kind, output label_text,
                  output label_length, output value_word0, output value_word1,
                  output value_word2, output value_word3, output value_length,
                  output frame_valid, input ready);
  modport sink   (input valid, input event_kind, input label_text,
                  input label_length, input value_word0, input value_word1,
                  input value_word2, input value_word3, input value_length,
                  input frame_valid, output ready);
endinterface

// ===== rtl/core/text_frame_record_parser.sv =====
// Text frame record parser: LABEL<tab>VALUE<cr><lf> lines into records.
// Depends on tfrp_pkg and the channel interfaces in tfrp_ifs.sv.
//
// Usage:
//   in_if  carries one raw received byte per request (rx_byte).
//   out_if carries one result per completed line: a record (label and value
//   text, upper-cased and truncated) or, for the CHECKSUM line, a frame end
//   whose frame_valid is set when the 8-bit sum of the frame's bytes is zero.
//   Most bytes produce no result; a line feed ending a line produces one.
// Timing:
//   One byte is taken every cycle while in_if.ready is high. A result appears on
//   out_if in the cycle after the line feed that completes it; the parse state,
//   label and value buffers update at the clock edge that takes the byte.
// Stall:
//   A single result register sits on the output. While it holds a result the
//   receiver has not taken, in_if.ready drops; it rises again in the cycle the
//   result is taken, so a ready receiver sees no gaps.
// Reset:
//   rst_n (synchronous, low) returns the parser to idle, clears the sum and
//   counts and empties the result register. Parsing restarts at the next
//   line feed.
module text_frame_record_parser #(
  parameter int unsigned VALUE_BYTES = tfrp_pkg::VALUE_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  tfrp_in_if.sink          in_if,
  tfrp_out_if.source       out_if
);
  import tfrp_pkg::*;

  localparam int unsigned VAL_MAX = VALUE_BYTES - 1;
  localparam int unsigned VIDX_W  = (VAL_MAX > 1) ? $clog2(VAL_MAX) : 1;

  // Parser state
  parse_phase_t           phase_r, phase_nxt;
  logic [BYTE_W-1:0]      sum_r, sum_nxt;
  logic [LABEL_LEN_W-1:0] label_count_r, label_count_nxt;
  logic [VALUE_LEN_W-1:0] value_count_r, value_count_nxt;
  logic [BYTE_W-1:0]      label_store_r [LABEL_MAX];
  logic [BYTE_W-1:0]      value_store_r [VAL_MAX];

  // Result register
  logic                   out_valid_r;
  logic                   out_kind_r, out_kind_nxt;
  logic [TEXT_W-1:0]      out_label_r, out_label_nxt;
  logic [LABEL_LEN_W-1:0] out_llen_r, out_llen_nxt;
  logic [TEXT_W-1:0]      out_word_r [VALUE_WORDS];
  logic [TEXT_W-1:0]      out_word_nxt [VALUE_WORDS];
  logic [VALUE_LEN_W-1:0] out_vlen_r, out_vlen_nxt;
  logic                   out_fv_r, out_fv_nxt;

  logic                   accept;
  logic                   is_colon_abort;
  logic [BYTE_W-1:0]      c;
  logic [BYTE_W-1:0]      sum_add;
  logic [TEXT_W-1:0]      label_packed;
  logic [TEXT_W-1:0]      label_masked;
  logic [BYTE_W-1:0]      value_bytes [VALUE_SLOTS];
  logic                   emit;
  logic                   label_we;
  logic [2:0]             label_widx;
  logic                   value_we;

  assign accept         = in_if.valid && in_if.ready;
  assign in_if.ready    = !out_valid_r || out_if.ready;
  assign c              = upcase(in_if.rx_byte);
  assign sum_add        = sum_r + in_if.rx_byte;
  assign is_colon_abort = (in_if.rx_byte == CH_COLON) && (phase_r != PH_CSUM);

  // Label buffer packed, and masked to the valid length
  always_comb begin
    for (int i = 0; i < LABEL_MAX; i++) begin
      label_packed[i*BYTE_W +: BYTE_W] = label_store_r[i];
      label_masked[i*BYTE_W +: BYTE_W] =
        (LABEL_LEN_W'(i) < label_count_r) ? label_store_r[i] : '0;
    end
  end

  // Value buffer bytes masked to the valid length, zero past the buffer
  for (genvar g = 0; g < VALUE_SLOTS; g++) begin : g_vbyte
    if (g < VAL_MAX) begin : g_live
      assign value_bytes[g] =
        (VALUE_LEN_W'(g) < value_count_r) ? value_store_r[g] : '0;
    end else begin : g_pad
      assign value_bytes[g] = '0;
    end
  end

  // Next parse phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (is_colon_abort) begin
        phase_nxt = PH_IDLE;
      end else begin
        unique case (phase_r)
          PH_BEGIN: phase_nxt = PH_LABEL;
          PH_LABEL: begin
            if (c == CH_TAB) begin
              phase_nxt = (label_count_r == LABEL_LEN_W'(LABEL_MAX) &&
                           label_packed == CSUM_LABEL) ? PH_CSUM : PH_VALUE;
            end
          end
          PH_VALUE: if (c == CH_LF) phase_nxt = PH_BEGIN;
          PH_CSUM:  if (c == CH_LF) phase_nxt = PH_IDLE;
          default:  if (c == CH_LF) phase_nxt = PH_BEGIN;
        endcase
      end
    end
  end

  // Datapath controls: sum, counts, buffer writes, result
  always_comb begin
    sum_nxt         = sum_r;
    label_count_nxt = label_count_r;
    value_count_nxt = value_count_r;
    label_we        = 1'b0;
    label_widx      = label_count_r[2:0];
    value_we        = 1'b0;
    emit            = 1'b0;
    out_kind_nxt    = EV_RECORD;
    out_label_nxt   = label_masked;
    out_llen_nxt    = label_count_r;
    out_vlen_nxt    = value_count_r;
    out_fv_nxt      = 1'b0;
    for (int w = 0; w < VALUE_WORDS; w++) begin
      for (int b = 0; b < TEXT_W / BYTE_W; b++) begin
        out_word_nxt[w][b*BYTE_W +: BYTE_W] = value_bytes[w*(TEXT_W/BYTE_W) + b];
      end
    end
    if (accept) begin
      if (is_colon_abort) begin
        sum_nxt = '0;
      end else begin
        if (phase_r == PH_BEGIN || phase_r == PH_LABEL ||
            phase_r == PH_VALUE || phase_r == PH_CSUM) begin
          sum_nxt = sum_add;
        end
        unique case (phase_r)
          PH_BEGIN: begin
            label_we        = 1'b1;
            label_widx      = '0;
            label_count_nxt = LABEL_LEN_W'(1);
          end
          PH_LABEL: begin
            if (c == CH_TAB) begin
              value_count_nxt = '0;
            end else if (label_count_r < LABEL_LEN_W'(LABEL_MAX)) begin
              label_we        = 1'b1;
              label_count_nxt = label_count_r + 1'b1;
            end
          end
          PH_VALUE: begin
            if (c == CH_LF) begin
              emit = 1'b1;
            end else if (c != CH_CR && value_count_r < VALUE_LEN_W'(VAL_MAX)) begin
              value_we        = 1'b1;
              value_count_nxt = value_count_r + 1'b1;
            end
          end
          PH_CSUM: begin
            if (c == CH_LF) begin
              emit          = 1'b1;
              out_kind_nxt  = EV_FRAME_END;
              out_label_nxt = '0;
              out_llen_nxt  = '0;
              out_vlen_nxt  = '0;
              out_fv_nxt    = (sum_add == '0);
              for (int w = 0; w < VALUE_WORDS; w++) begin
                out_word_nxt[w] = '0;
              end
            end
          end
          default: if (c == CH_LF) sum_nxt = '0;
        endcase
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      sum_r         <= '0;
      label_count_r <= '0;
      value_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      sum_r         <= sum_nxt;
      label_count_r <= label_count_nxt;
      value_count_r <= value_count_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Text buffers
  always_ff @(posedge clk) begin
    if (label_we) begin
      label_store_r[label_widx] <= c;
    end
    if (value_we) begin
      value_store_r[value_count_r[VIDX_W-1:0]] <= c;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r  <= out_kind_nxt;
      out_label_r <= out_label_nxt;
      out_llen_r  <= out_llen_nxt;
      out_vlen_r  <= out_vlen_nxt;
      out_fv_r    <= out_fv_nxt;
      for (int w = 0; w < VALUE_WORDS; w++) begin
        out_word_r[w] <= out_word_nxt[w];
      end
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.event_kind   = out_kind_r;
  assign out_if.label_text   = out_label_r;
  assign out_if.label_length = out_llen_r;
  assign out_if.value_word0  = out_word_r[0];
  assign out_if.value_word1  = out_word_r[1];
  assign out_if.value_word2  = out_word_r[2];
  assign out_if.value_word3  = out_word_r[3];
  assign out_if.value_length = out_vlen_r;
  assign out_if.frame_valid  = out_fv_r;

endmodule

// ===== rtl/core/tfrp_checker.sv =====
// Port-level checks for text_frame_record_parser, attached by bind.
// Depends on tfrp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tfrp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_event_kind,
  input logic [tfrp_pkg::TEXT_W-1:0]     out_label_text,
  input logic [tfrp_pkg::LABEL_LEN_W-1:0] out_label_length,
  input logic [tfrp_pkg::VALUE_LEN_W-1:0] out_value_length,
  input logic                            out_frame_valid
);
  import tfrp_pkg::*;

  // A stalled result stays in place
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_label_text) && $stable(out_event_kind), "stalled result changed")

  // A pending result that is not taken blocks new requests
  `ASSERT_SAME(a_backpressure, out_valid && !out_ready, !in_ready, "request taken while result stalled")

  // Frame end carries no text
  `ASSERT_SAME(a_frame_end_empty, out_valid && out_event_kind == EV_FRAME_END, out_label_length == '0 && out_value_length == '0 && out_label_text == '0, "frame end with text")

  // Records stay within buffer limits and never flag a frame
  `ASSERT_SAME(a_record_bounds, out_valid && out_event_kind == EV_RECORD, !out_frame_valid && out_label_length <= LABEL_LEN_W'(LABEL_MAX) && out_value_length <= VALUE_LEN_W'(VALUE_SLOTS), "record fields out of range")

endmodule

bind text_frame_record_parser tfrp_checker u_tfrp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_if.ready),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_event_kind   (out_if.event_kind),
  .out_label_text   (out_if.label_text),
  .out_label_length (out_if.label_length),
  .out_value_length (out_if.value_length),
  .out_frame_valid  (out_if.frame_valid)
);
